// ----- design/kwm_pkg.sv -----
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared sizes and types of the k-way sorted merge core.
// ----------------------------------------------------------------------------
package kwm_pkg;

	// Number of sequences (cells) and values held per sequence.
	localparam int LISTS = 8;
	localparam int DEPTH = 8;

	// Fixed field widths.
	localparam int LID_W = 3;
	localparam int VAL_W = 32;

	// Derived widths.
	localparam int CIDX_W = $clog2(LISTS);
	localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int TOT_W  = $clog2(LISTS * DEPTH + 1);
	localparam int WV_W   = $clog2(LISTS + 1);

	// Action codes carried on the request channel.
	localparam logic ACT_APPEND = 1'b0;
	localparam logic ACT_FINISH = 1'b1;

	// Best head seen so far, handed from cell to cell.
	typedef struct packed {
		logic                    vld;
		logic signed [VAL_W-1:0] val;
		logic [CIDX_W-1:0]       idx;
	} cand_t;

	// Commands broadcast from the controller to every cell.
	typedef struct packed {
		logic              app;
		logic              pop;
		logic              clr;
		logic [CIDX_W-1:0] tgt;
		logic [VAL_W-1:0]  data;
	} cell_ctl_t;

endpackage

// ----- design/kwm_in_if.sv -----
// ----------------------------------------------------------------------------
// kwm_in_if
// Valid/ready channel carrying append and finish beats.
// ----------------------------------------------------------------------------
interface kwm_in_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 action;
	logic [kwm_pkg::LID_W-1:0]            list_id;
	logic signed [kwm_pkg::VAL_W-1:0]     value;

	modport source (output valid, action, list_id, value, input ready);
	modport sink (input valid, action, list_id, value, output ready);
endinterface

// ----- design/kwm_out_if.sv -----
// ----------------------------------------------------------------------------
// kwm_out_if
// Valid/ready channel carrying merged result beats.
// ----------------------------------------------------------------------------
interface kwm_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [kwm_pkg::VAL_W-1:0]     value_res;
	logic [kwm_pkg::LID_W-1:0]            source_list;
	logic                                 last;
	logic                                 overflowed;

	modport source (output valid, value_res, source_list, last, overflowed, input ready);
	modport sink (input valid, value_res, source_list, last, overflowed, output ready);
endinterface

// ----- design/k_way_sorted_merge_core.sv -----
// ----------------------------------------------------------------------------
// k_way_sorted_merge_core
// Stores up to LISTS sorted sequences and emits them as one merged run.
// ----------------------------------------------------------------------------
// Usage: the req channel carries one beat per item. An append beat
// (action 0) stores value at the end of sequence list_id, and appends
// stream at one beat per cycle while req is ready. Appends to a full
// sequence are dropped and set the sticky overflow flag; a list_id of LISTS
// or more is ignored. A finish beat (action 1) starts the merge, during which
// req.ready is low. Each sequence lives in its own cell, and the cells form a
// registered chain that hands the smallest head seen so far to its right
// neighbor every cycle. Each pick lets the heads ripple through the whole
// chain and then pops the winning head into the output register, so the
// merge produces results one at a time, a new pick starting only after the
// last pop. Ties go to the lower sequence number. The final beat carries
// last; on that cycle the store and the overflow flag are emptied and req
// becomes ready again. A finish with nothing stored gives no beats and only
// clears the flag. Results sit in an output register: when the receiver
// stalls, the merge holds until the register is free, and no beat is lost.
// Reset empties every sequence and clears the flag and all valid bits.
// ----------------------------------------------------------------------------
module k_way_sorted_merge_core (
	input  logic       clk,
	input  logic       arst_n,
	kwm_in_if.sink     req,
	kwm_out_if.source  rsp
);

	localparam logic S_IDLE  = 1'b0;
	localparam logic S_MERGE = 1'b1;

	logic                          state_q;
	logic [kwm_pkg::WV_W-1:0]      cnt_q;
	logic [kwm_pkg::TOT_W-1:0]     tot_q;
	logic                          ovf_q;

	logic                          out_vld_q;
	logic signed [kwm_pkg::VAL_W-1:0] out_val_q;
	logic [kwm_pkg::LID_W-1:0]     out_src_q;
	logic                          out_last_q;
	logic                          out_ovf_q;

	kwm_pkg::cand_t                chain [kwm_pkg::LISTS+1];
	kwm_pkg::cell_ctl_t            ctl;
	logic [kwm_pkg::LISTS-1:0]     full_vec;

	logic                          acc;
	logic                          acc_app;
	logic                          acc_fin;
	logic                          in_range;
	logic [kwm_pkg::CIDX_W-1:0]    in_tgt;
	logic                          tgt_full;
	logic                          wave_done;
	logic                          emit;
	logic                          emit_last;
	logic                          fin_empty;
	kwm_pkg::cand_t                best;

	assign req.ready = (state_q == S_IDLE);
	assign acc       = req.valid && req.ready;
	assign acc_app   = acc && (req.action == kwm_pkg::ACT_APPEND);
	assign acc_fin   = acc && (req.action == kwm_pkg::ACT_FINISH);
	assign in_range  = (32'(req.list_id) < 32'(kwm_pkg::LISTS));
	assign in_tgt    = kwm_pkg::CIDX_W'(req.list_id);
	assign tgt_full  = full_vec[in_tgt];
	assign fin_empty = acc_fin && (tot_q == '0);

	// The chain end holds the smallest head once the heads have rippled
	// through every cell since they last changed.
	assign best      = chain[kwm_pkg::LISTS];
	assign wave_done = (state_q == S_MERGE) && (cnt_q == kwm_pkg::WV_W'(kwm_pkg::LISTS));
	assign emit      = wave_done && (!out_vld_q || rsp.ready);
	assign emit_last = emit && (tot_q == kwm_pkg::TOT_W'(1));

	always_comb begin
		ctl.app  = acc_app && in_range && !tgt_full;
		ctl.pop  = emit && !emit_last;
		ctl.clr  = fin_empty || emit_last;
		ctl.tgt  = emit ? best.idx : in_tgt;
		ctl.data = req.value;
	end

	assign chain[0] = '0;

	for (genvar i = 0; i < kwm_pkg::LISTS; i++) begin : g_cell
		kwm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (kwm_pkg::CIDX_W'(i)),
			.ctl      (ctl),
			.cand_in  (chain[i]),
			.cand_out (chain[i+1]),
			.full     (full_vec[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			tot_q     <= '0;
			ovf_q     <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			// A new result refills the output register even as the old one leaves.
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc_app && in_range) begin
						if (tgt_full) begin
							ovf_q <= 1'b1;
						end else begin
							tot_q <= tot_q + 1'b1;
						end
					end
					if (acc_fin) begin
						cnt_q <= '0;
						if (tot_q == '0) begin
							ovf_q <= 1'b0;
						end else begin
							state_q <= S_MERGE;
						end
					end
				end
				S_MERGE: begin
					if (emit) begin
						cnt_q     <= '0;
						tot_q     <= tot_q - 1'b1;
						if (emit_last) begin
							ovf_q   <= 1'b0;
							state_q <= S_IDLE;
						end
					end else if (!wave_done) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_val_q  <= best.val;
			out_src_q  <= kwm_pkg::LID_W'(best.idx);
			out_last_q <= emit_last;
			out_ovf_q  <= ovf_q;
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.value_res   = out_val_q;
	assign rsp.source_list = out_src_q;
	assign rsp.last        = out_last_q;
	assign rsp.overflowed  = out_ovf_q;

	// A merge only runs while values remain to be emitted.
	a_merge_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MERGE |-> tot_q != '0)
		else $error("merge running with an empty store");

	// A finished wave always finds some head while values remain.
	a_wave_found: assert property (@(posedge clk) disable iff (!arst_n)
		wave_done |-> best.vld)
		else $error("chain end holds no candidate");

	// The final result returns the block to idle with the store emptied.
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		emit_last |=> state_q == S_IDLE && tot_q == '0 && !ovf_q)
		else $error("store not emptied after the final result");

	// An empty finish clears the overflow flag and stays idle.
	a_empty_finish: assert property (@(posedge clk) disable iff (!arst_n)
		fin_empty |=> state_q == S_IDLE && !ovf_q)
		else $error("empty finish left state behind");

endmodule

// ----- design/kwm_cell.sv -----
// ----------------------------------------------------------------------------
// kwm_cell
// One sequence: its value store, fill count and head pointer, plus one
// registered stage of the minimum chain.
// ----------------------------------------------------------------------------
module kwm_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [kwm_pkg::CIDX_W-1:0]   idx,
	input  kwm_pkg::cell_ctl_t           ctl,
	input  kwm_pkg::cand_t               cand_in,
	output kwm_pkg::cand_t               cand_out,
	output logic                         full
);

	logic [kwm_pkg::VAL_W-1:0] mem_q [kwm_pkg::DEPTH];
	logic [kwm_pkg::CNT_W-1:0] fill_q;
	logic [kwm_pkg::CNT_W-1:0] rd_q;
	kwm_pkg::cand_t            cand_q;
	logic                      mine;
	logic                      has;
	logic signed [kwm_pkg::VAL_W-1:0] head;
	logic                      take;

	assign mine = (ctl.tgt == idx);
	assign full = (fill_q == kwm_pkg::CNT_W'(kwm_pkg::DEPTH));
	assign has  = (rd_q < fill_q);
	assign head = $signed(mem_q[rd_q[kwm_pkg::PTR_W-1:0]]);
	// Strict compare keeps the left (lower numbered) candidate on a tie.
	assign take = has && (!cand_in.vld || (head < cand_in.val));
	assign cand_out = cand_q;

	always_ff @(posedge clk) begin
		if (ctl.app && mine && !full) begin
			mem_q[fill_q[kwm_pkg::PTR_W-1:0]] <= ctl.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			rd_q   <= '0;
			cand_q <= '0;
		end else begin
			if (ctl.clr) begin
				fill_q <= '0;
				rd_q   <= '0;
			end else begin
				if (ctl.app && mine && !full) begin
					fill_q <= fill_q + 1'b1;
				end
				if (ctl.pop && mine) begin
					rd_q <= rd_q + 1'b1;
				end
			end
			if (take) begin
				cand_q.vld <= 1'b1;
				cand_q.val <= head;
				cand_q.idx <= idx;
			end else begin
				cand_q <= cand_in;
			end
		end
	end

endmodule

// ----- tb/sv/tb_k_way_sorted_merge_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_k_way_sorted_merge_core
// Self-checking bench that streams sequences in and checks the merged run.
// Append and finish beats are queued up front and fed to the core by a
// clocked driver. Every accepted beat also updates a local copy of the
// sequence store, and each finish beat predicts the whole merged run. A
// clocked monitor compares each result beat with the oldest prediction. The
// run passes through three pacing phases for the sender and the receiver.
// ----------------------------------------------------------------------------
module tb_k_way_sorted_merge_core;

	// Sizes shared with the design.
	localparam int LISTS = kwm_pkg::LISTS;
	localparam int DEPTH = kwm_pkg::DEPTH;
	localparam int LID_W = kwm_pkg::LID_W;
	localparam int VAL_W = kwm_pkg::VAL_W;

	// Action codes carried on the request channel.
	localparam logic ACT_APPEND = kwm_pkg::ACT_APPEND;
	localparam logic ACT_FINISH = kwm_pkg::ACT_FINISH;

	// Shapes of one random run of appends closed by a finish.
	localparam int RUN_EMPTY    = 0;
	localparam int RUN_UNSORTED = 1;
	localparam int RUN_OVERRUN  = 2;
	localparam int RUN_FULL     = 3;

	localparam int ITEM_GOAL = 430;
	// One result beat needs a full ripple through the cell chain plus a pop.
	localparam int PICK_CYCLES = LISTS + 1;

	typedef struct {
		logic                    action;
		logic [LID_W-1:0]        list_id;
		logic signed [VAL_W-1:0] value;
	} req_item_t;

	typedef struct {
		logic signed [VAL_W-1:0] value_res;
		logic [LID_W-1:0]        source_list;
		logic                    last;
		logic                    overflowed;
	} merged_beat_t;

	logic clk;
	logic arst_n;

	kwm_in_if  req ();
	kwm_out_if rsp ();

	k_way_sorted_merge_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	// Beats still to be offered, and merged results still to arrive.
	req_item_t    pending_items[$];
	merged_beat_t merged_expected[$];

	// Local copy of the core's sequence store.
	logic signed [VAL_W-1:0] seq_store [LISTS][DEPTH];
	int                      fill_count [LISTS];
	bit                      overflow_seen;

	int           item_total;
	int           beats_in;
	int           mismatch_count;
	req_item_t    next_item;
	merged_beat_t want;

	always #10 clk = ~clk;

	// The run is split into thirds by accepted request beats. In the first
	// third the receiver stalls heavily, in the second the sender does, and
	// in the last third neither side holds back.
	function automatic int idle_phase();
		return (item_total == 0) ? 0 : (beats_in * 3) / item_total;
	endfunction

	function automatic int send_idle_pct();
		case (idle_phase())
			0: begin
				return 29;
			end
			1: begin
				return 74;
			end
			default: begin
				return 0;
			end
		endcase
	endfunction

	function automatic int recv_idle_pct();
		case (idle_phase())
			0: begin
				return 74;
			end
			1: begin
				return 29;
			end
			default: begin
				return 0;
			end
		endcase
	endfunction

	task automatic queue_item(input logic action, input int list_id, input int value);
		req_item_t item;
		item.action  = action;
		item.list_id = list_id[LID_W-1:0];
		item.value   = value;
		pending_items.push_back(item);
	endtask

	// Applies one accepted beat to the local store. A finish beat walks the
	// heads exactly as the core does: the smallest head wins, and on a tie the
	// lower sequence number wins because only a strictly smaller value
	// replaces the current pick. The store and the flag are cleared afterwards.
	task automatic merge_predict(input logic action, input logic [LID_W-1:0] list_id,
			input logic signed [VAL_W-1:0] value);
		merged_beat_t beat;
		int           heads [LISTS];
		int           total;
		int           pick;
		if (action == ACT_APPEND) begin
			// An id of LISTS or more is ignored; a full sequence drops the value.
			if (int'(list_id) < LISTS) begin
				if (fill_count[list_id] < DEPTH) begin
					seq_store[list_id][fill_count[list_id]] = value;
					fill_count[list_id]++;
				end else begin
					overflow_seen = 1'b1;
				end
			end
		end else begin
			total = 0;
			for (int s = 0; s < LISTS; s++) begin
				heads[s] = 0;
				total += fill_count[s];
			end
			for (int n = 0; n < total; n++) begin
				pick = -1;
				for (int s = 0; s < LISTS; s++) begin
					if (heads[s] < fill_count[s]) begin
						if (pick < 0 || seq_store[s][heads[s]] < seq_store[pick][heads[pick]]) begin
							pick = s;
						end
					end
				end
				beat.value_res   = seq_store[pick][heads[pick]];
				beat.source_list = pick[LID_W-1:0];
				beat.last        = (n == total - 1);
				beat.overflowed  = overflow_seen;
				merged_expected.push_back(beat);
				heads[pick]++;
			end
			for (int s = 0; s < LISTS; s++) begin
				fill_count[s] = 0;
			end
			overflow_seen = 1'b0;
		end
	endtask

	// Queues one run of appends, interleaved across sequences at random,
	// closed by a finish beat with random unused fields. Most runs hold
	// ascending sequences of a few values; narrow value ranges force ties.
	task automatic queue_random_run();
		int     vals [LISTS][DEPTH+3];
		int     len [LISTS];
		int     rem [LISTS];
		int     shape;
		int     left;
		int     s;
		int     step_max;
		bit     narrow;
		longint v;
		shape  = $urandom_range(19);
		narrow = ($urandom_range(2) == 0);
		for (int i = 0; i < LISTS; i++) begin
			if (shape == RUN_EMPTY) begin
				len[i] = 0;
			end else if (shape == RUN_FULL) begin
				len[i] = DEPTH;
			end else begin
				len[i] = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 3);
			end
		end
		if (shape == RUN_OVERRUN) begin
			len[$urandom_range(LISTS-1)] = DEPTH + $urandom_range(1, 3);
		end
		left = 0;
		for (int i = 0; i < LISTS; i++) begin
			if (narrow) begin
				v        = longint'($urandom_range(0, 4)) - 2;
				step_max = 1;
			end else begin
				case ($urandom_range(7))
					0: begin
						v = -64'sd2147483648;
					end
					1: begin
						v = 64'sd2147483647 - $urandom_range(3);
					end
					default: begin
						v = longint'(int'($urandom));
					end
				endcase
				step_max = 1 << $urandom_range(4, 28);
			end
			for (int k = 0; k < len[i]; k++) begin
				vals[i][k] = (shape == RUN_UNSORTED) ? int'($urandom) : int'(v);
				v += $urandom_range(0, step_max);
				if (v > 64'sd2147483647) begin
					v = 64'sd2147483647;
				end
			end
			rem[i] = len[i];
			left += len[i];
		end
		while (left > 0) begin
			s = $urandom_range(LISTS-1);
			if (rem[s] != 0) begin
				queue_item(ACT_APPEND, s, vals[s][len[s] - rem[s]]);
				rem[s]--;
				left--;
			end
		end
		queue_item(ACT_FINISH, $urandom_range((1 << LID_W) - 1), int'($urandom));
	endtask

	task automatic check_field(input string what, input longint expected_val,
			input longint actual_val);
		if (expected_val != actual_val) begin
			$display("%0t: %s expected %0d, got %0d", $time, what, expected_val, actual_val);
			mismatch_count++;
		end
	endtask

	// Driver: a beat stays on the channel until it is taken. The prediction is
	// made on the edge where the beat is accepted, so expectations are queued
	// long before the merge can produce anything.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid   <= 1'b0;
			req.action  <= ACT_APPEND;
			req.list_id <= '0;
			req.value   <= '0;
		end else begin
			if (req.valid && req.ready) begin
				merge_predict(req.action, req.list_id, req.value);
				beats_in <= beats_in + 1;
			end
			if (!req.valid || req.ready) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
					next_item = pending_items.pop_front();
					req.valid   <= 1'b1;
					req.action  <= next_item.action;
					req.list_id <= next_item.list_id;
					req.value   <= next_item.value;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: every accepted result beat must match the oldest prediction,
	// field by field. The ready line is rolled fresh on every cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (merged_expected.size() == 0) begin
					$display("%0t: result beat with none expected, got value %0d from list %0d",
						$time, rsp.value_res, rsp.source_list);
					mismatch_count++;
				end else begin
					want = merged_expected.pop_front();
					check_field("value_res", want.value_res, rsp.value_res);
					check_field("source_list", want.source_list, rsp.source_list);
					check_field("last", want.last, rsp.last);
					check_field("overflowed", want.overflowed, rsp.overflowed);
				end
			end
			rsp.ready <= ($urandom_range(99) >= recv_idle_pct());
		end
	end

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		req.valid      = 1'b0;
		req.action     = ACT_APPEND;
		req.list_id    = '0;
		req.value      = '0;
		rsp.ready      = 1'b0;
		item_total     = 0;
		beats_in       = 0;
		mismatch_count = 0;
		overflow_seen  = 1'b0;
		for (int s = 0; s < LISTS; s++) begin
			fill_count[s] = 0;
		end

		// Directed run: both extremes of the value range, a tie between two
		// sequences, a repeated value inside one sequence, a sequence that is
		// overrun by one beat, and a sequence appended out of order. The
		// finish carries junk in its unused fields, and a second finish then
		// hits an empty store.
		queue_item(ACT_APPEND, 0, -2147483648);
		queue_item(ACT_APPEND, 7, 2147483647);
		queue_item(ACT_APPEND, 3, 5);
		queue_item(ACT_APPEND, 2, 5);
		queue_item(ACT_APPEND, 1, 0);
		queue_item(ACT_APPEND, 1, 0);
		for (int k = 0; k <= DEPTH; k++) begin
			queue_item(ACT_APPEND, 4, k * 3 - 10);
		end
		queue_item(ACT_APPEND, 5, 10);
		queue_item(ACT_APPEND, 5, -10);
		queue_item(ACT_FINISH, 7, 32'hDEAD_BEEF);
		queue_item(ACT_FINISH, 0, 0);

		while (pending_items.size() < ITEM_GOAL) begin
			queue_random_run();
		end
		item_total = pending_items.size();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || req.valid) begin
			@(posedge clk);
		end
		while (merged_expected.size() != 0) begin
			@(posedge clk);
		end
		// Leave room for any stray beat the core might still push out.
		repeat (4 * PICK_CYCLES) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Hard stop well beyond the slowest correct run.
	initial begin
		#4000000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ----- sim.f -----
design/kwm_pkg.sv
design/kwm_in_if.sv
design/kwm_out_if.sv
design/kwm_cell.sv
design/k_way_sorted_merge_core.sv
tb/sv/tb_k_way_sorted_merge_core.sv
